// ----- rtl/core/sliding_quadratic_fit_velocity_unit_macros.svh -----
// Assertion macros shared by the checker of the quadratic fit velocity unit
`ifndef SLIDING_QUADRATIC_FIT_VELOCITY_UNIT_MACROS_SVH
`define SLIDING_QUADRATIC_FIT_VELOCITY_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SQFV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SQFV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sqfv_pkg.sv -----
// Types, sizes and fit coefficient function for the quadratic fit velocity unit
package sqfv_pkg;

  localparam int WINDOW         = 8;
  localparam int COEF_FRAC_BITS = 30;

  localparam int SAMPLE_W  = 32;
  localparam int RESULT_W  = 48;
  localparam int RATE_W    = 32;
  localparam int COEF_W    = COEF_FRAC_BITS + 3;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int ACC_W     = PROD_W + $clog2(WINDOW);
  localparam int RND_SHIFT = COEF_FRAC_BITS - 16;
  localparam int Q_W       = (ACC_W + 1 > 64) ? ACC_W + 1 : 64;
  localparam int MAG_W     = 63;

  localparam logic [RATE_W-1:0] RATE_RESET = 32'd6553600;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESULT_W-1:0] result_t;
  typedef logic [RATE_W-1:0]          rate_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [ACC_W:0]      rnd_t;
  typedef logic signed [Q_W-1:0]      q_t;
  typedef logic [MAG_W-1:0]           mag_t;

  typedef struct packed {
    acc_t pos;
    acc_t vel;
  } acc_pair_t;

  // Savitzky-Golay endpoint coefficient for tap k (0 = oldest), value or slope,
  // COEF_FRAC_BITS fraction bits, rounded to nearest with ties away from zero.
  // Evaluated at elaboration only.
  function automatic coef_t fit_coef(input int k, input logic slope);
    longint     n;
    longint     q;
    longint     se;
    longint     ae;
    longint     sk;
    longint     ak;
    longint     num;
    logic [127:0] mag;
    logic [127:0] rem;
    logic [127:0] quo;
    logic [127:0] den;
    logic       neg;
    n   = longint'(WINDOW);
    q   = n * n;
    se  = n - 1;
    ae  = 3 * se * se - (q - 1);
    den = 128'(4 * n * (q - 1) * (q - 4));
    sk  = 2 * longint'(k) - (n - 1);
    ak  = 3 * sk * sk - (q - 1);
    if (slope) begin
      num = 24 * sk * (q - 4) + 60 * ak * se;
    end else begin
      num = 4 * (q - 1) * (q - 4) + 12 * sk * se * (q - 4) + 5 * ak * ae;
    end
    neg = (num < 0);
    mag = neg ? 128'(-num) : 128'(num);
    mag = mag << COEF_FRAC_BITS;
    rem = '0;
    quo = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], mag[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    if ((rem << 1) >= den) begin
      quo = quo + 128'd1;
    end
    if (neg) begin
      quo = -quo;
    end
    return coef_t'(quo);
  endfunction

endpackage

// ----- rtl/core/sliding_quadratic_fit_velocity_unit.sv -----
// Top level: sliding quadratic fit of position samples giving position and velocity
// Result path: registered through the filter tap, round, scale and saturate stages after the input transaction.
// Throughput: one transaction in flight; next input taken the cycle after the result is taken,
// so a new sample waits until the previous result has passed the rounding and rate multiply path.
// Reset (synchronous, active low): all tap partial sums zero, so unfilled window slots read
// as zero samples; sample_rate returns to 6553600 (100 Hz in Q16.16); no result pending.
module sliding_quadratic_fit_velocity_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           in_position_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [47:0]           out_fitted_position,
  output logic signed [47:0]           out_fitted_velocity,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [31:0]                  cfg_sample_rate
);

  logic                busy_r;
  logic                busy_nxt;
  logic                in_take;
  sqfv_pkg::rate_t     rate_r;
  sqfv_pkg::rate_t     rate_nxt;
  sqfv_pkg::acc_pair_t acc_chain [sqfv_pkg::WINDOW+1];
  sqfv_pkg::result_t   post_pos;
  sqfv_pkg::result_t   post_vel;

  assign in_stall  = busy_r || !rst_n;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    busy_nxt = busy_r;
    if (in_take) begin
      busy_nxt = 1'b1;
    end else if (out_valid && !out_stall) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    rate_nxt = rate_r;
    if (cfg_valid && cfg_ready) begin
      rate_nxt = cfg_sample_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rate_r <= sqfv_pkg::RATE_RESET;
    end else begin
      busy_r <= busy_nxt;
      rate_r <= rate_nxt;
    end
  end

  assign acc_chain[0] = '0;

  // tap k carries the coefficient for the sample k places from the oldest
  for (genvar k = 0; k < sqfv_pkg::WINDOW; k++) begin : g_tap
    localparam sqfv_pkg::coef_t PC = sqfv_pkg::fit_coef(k, 1'b0);
    localparam sqfv_pkg::coef_t VC = sqfv_pkg::fit_coef(k, 1'b1);
    sqfv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (in_take),
      .x        (in_position_sample),
      .pos_coef (PC),
      .vel_coef (VC),
      .acc_in   (acc_chain[k]),
      .acc_out  (acc_chain[k+1])
    );
  end

  sqfv_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .sum       (acc_chain[sqfv_pkg::WINDOW]),
    .rate      (rate_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_pos   (post_pos),
    .out_vel   (post_vel)
  );

  assign out_fitted_position = post_pos;
  assign out_fitted_velocity = post_vel;

endmodule

// ----- rtl/core/sqfv_cell.sv -----
// One tap of the transposed fit filter: multiply-accumulate for value and slope
module sqfv_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  sqfv_pkg::sample_t   x,
  input  sqfv_pkg::coef_t     pos_coef,
  input  sqfv_pkg::coef_t     vel_coef,
  input  sqfv_pkg::acc_pair_t acc_in,
  output sqfv_pkg::acc_pair_t acc_out
);

  sqfv_pkg::acc_pair_t acc_r;
  sqfv_pkg::acc_pair_t acc_nxt;
  sqfv_pkg::prod_t     pos_prod;
  sqfv_pkg::prod_t     vel_prod;

  assign pos_prod = sqfv_pkg::prod_t'(pos_coef) * sqfv_pkg::prod_t'(x);
  assign vel_prod = sqfv_pkg::prod_t'(vel_coef) * sqfv_pkg::prod_t'(x);

  always_comb begin
    acc_nxt.pos = acc_in.pos + sqfv_pkg::acc_t'(pos_prod);
    acc_nxt.vel = acc_in.vel + sqfv_pkg::acc_t'(vel_prod);
  end

  // partial sums are the window state: zero after reset means empty slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_out = acc_r;

endmodule

// ----- rtl/core/sqfv_post.sv -----
// Rounding, saturation and sample rate scaling of the fit sums, with output register
module sqfv_post (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  sqfv_pkg::acc_pair_t sum,
  input  sqfv_pkg::rate_t     rate,
  input  logic                out_stall,
  output logic                out_valid,
  output sqfv_pkg::result_t   out_pos,
  output sqfv_pkg::result_t   out_vel
);

  localparam sqfv_pkg::rnd_t RND_HALF = (sqfv_pkg::rnd_t'(1) << sqfv_pkg::RND_SHIFT) >>> 1;
  localparam sqfv_pkg::q_t   POS_MAX  = sqfv_pkg::q_t'(64'sh0000_7FFF_FFFF_FFFF);
  localparam sqfv_pkg::q_t   POS_MIN  = sqfv_pkg::q_t'(64'shFFFF_8000_0000_0000);
  localparam sqfv_pkg::q_t   VEL_MAX  = sqfv_pkg::q_t'(64'sh3FFF_FFFF_FFFF_FFFF);
  localparam sqfv_pkg::q_t   VEL_MIN  = sqfv_pkg::q_t'(64'shC000_0000_0000_0000);
  localparam logic [49:0]    LIM_POS  = 50'h0_7FFF_FFFF_FFFF;
  localparam logic [49:0]    LIM_NEG  = 50'h0_8000_0000_0000;

  function automatic sqfv_pkg::q_t to_q16(input sqfv_pkg::acc_t v, input sqfv_pkg::q_t lo,
                                          input sqfv_pkg::q_t hi);
    sqfv_pkg::rnd_t r;
    sqfv_pkg::q_t   e;
    r = (sqfv_pkg::rnd_t'(v) + RND_HALF) >>> sqfv_pkg::RND_SHIFT;
    e = sqfv_pkg::q_t'(r);
    if (e > hi) begin
      e = hi;
    end else if (e < lo) begin
      e = lo;
    end
    return e;
  endfunction

  // pipeline valids
  logic s0_vld_r;
  logic a_vld_r;
  logic b_vld_r;
  logic out_vld_r;
  logic out_vld_nxt;

  // stage A: rounded position, slope magnitude and sign
  sqfv_pkg::result_t pos_a_r;
  sqfv_pkg::result_t pos_a_nxt;
  sqfv_pkg::mag_t    mag_a_r;
  sqfv_pkg::mag_t    mag_a_nxt;
  logic              neg_a_r;
  logic              neg_a_nxt;

  // stage B: partial products with the sample rate
  sqfv_pkg::result_t pos_b_r;
  logic [62:0]       hp_b_r;
  logic [62:0]       hp_b_nxt;
  logic [63:0]       lo_b_r;
  logic [63:0]       lo_b_nxt;
  logic              neg_b_r;

  // stage C: output register
  sqfv_pkg::result_t pos_o_r;
  sqfv_pkg::result_t vel_o_r;
  sqfv_pkg::result_t vel_o_nxt;

  always_comb begin
    sqfv_pkg::q_t pq;
    sqfv_pkg::q_t vq;
    sqfv_pkg::q_t vm;
    pq        = to_q16(sum.pos, POS_MIN, POS_MAX);
    vq        = to_q16(sum.vel, VEL_MIN, VEL_MAX);
    vm        = vq[sqfv_pkg::Q_W-1] ? -vq : vq;
    pos_a_nxt = pq[sqfv_pkg::RESULT_W-1:0];
    neg_a_nxt = vq[sqfv_pkg::Q_W-1];
    mag_a_nxt = vm[sqfv_pkg::MAG_W-1:0];
  end

  always_comb begin
    hp_b_nxt = 63'(mag_a_r[62:32]) * 63'(rate);
    lo_b_nxt = 64'(mag_a_r[31:0]) * 64'(rate);
  end

  always_comb begin
    logic [64:0] lo_rnd;
    logic [49:0] tot;
    logic [49:0] lim;
    lo_rnd    = {1'b0, lo_b_r} + 65'h0_0000_0000_0000_8000;
    tot       = {3'b000, hp_b_r[30:0], 16'h0000} + {1'b0, lo_rnd[64:16]};
    lim       = neg_b_r ? LIM_NEG : LIM_POS;
    // high partial product beyond 31 bits puts the magnitude at or above the limit, so it saturates
    if ((|hp_b_r[62:31]) || (tot > lim)) begin
      tot = lim;
    end
    vel_o_nxt = neg_b_r ? -tot[sqfv_pkg::RESULT_W-1:0] : tot[sqfv_pkg::RESULT_W-1:0];
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (b_vld_r) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s0_vld_r  <= take;
      a_vld_r   <= s0_vld_r;
      b_vld_r   <= a_vld_r;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_vld_r) begin
      pos_a_r <= pos_a_nxt;
      mag_a_r <= mag_a_nxt;
      neg_a_r <= neg_a_nxt;
    end
    if (a_vld_r) begin
      pos_b_r <= pos_a_r;
      hp_b_r  <= hp_b_nxt;
      lo_b_r  <= lo_b_nxt;
      neg_b_r <= neg_a_r;
    end
    if (b_vld_r) begin
      pos_o_r <= pos_b_r;
      vel_o_r <= vel_o_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pos   = pos_o_r;
  assign out_vel   = vel_o_r;

endmodule

// ----- rtl/core/sqfv_checker.sv -----
// Port-level assertions for the quadratic fit velocity unit, bound to the top level
`include "sliding_quadratic_fit_velocity_unit_macros.svh"

module sqfv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] out_fitted_position,
  input logic signed [47:0] out_fitted_velocity
);

  logic        in_take;
  logic        out_hold;
  logic [95:0] out_data;

  assign in_take  = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;
  assign out_data = {out_fitted_position, out_fitted_velocity};

  `SQFV_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_data), "stalled result changed")
  `SQFV_ASSERT_NEXT(a_one_in_flight, in_take, in_stall, "input taken while busy")
  // result is offered once the input has passed the tap accumulators and the round, scale and output registers
  `SQFV_ASSERT_NEXT(a_latency, in_take, !out_valid [*3] ##1 out_valid, "result not on time")
  `SQFV_ASSERT_SAME(a_result_blocks_input, out_valid, in_stall, "input open with result pending")

endmodule

bind sliding_quadratic_fit_velocity_unit sqfv_checker u_sqfv_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_fitted_position (out_fitted_position),
  .out_fitted_velocity (out_fitted_velocity)
);

// ----- tb/sliding_quadratic_fit_velocity_unit_test.sv -----
// Testbench for the sliding quadratic fit velocity unit: predicted fit checked per transaction
`timescale 1ns / 100ps

module sliding_quadratic_fit_velocity_unit_test;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RND = sqfv_pkg::COEF_FRAC_BITS - 16;
  localparam logic signed [127:0] POS_MAX = (128'sd1 <<< 47) - 1;
  localparam logic signed [127:0] SLOPE_MAX = (128'sd1 <<< 62) - 1;
  localparam sqfv_pkg::sample_t SAMPLE_MAX = 32'sh7FFFFFFF;
  localparam sqfv_pkg::sample_t SAMPLE_MIN = 32'sh80000000;

  // Predictor and result store for the fitted position and velocity
  class velocity_fit_model;
    sqfv_pkg::sample_t history[sqfv_pkg::WINDOW-1];
    sqfv_pkg::rate_t rate;
    logic signed [63:0] pos_tap[sqfv_pkg::WINDOW];
    logic signed [63:0] vel_tap[sqfv_pkg::WINDOW];
    sqfv_pkg::result_t expected_position[$];
    sqfv_pkg::result_t expected_velocity[$];
    int errors;
    int checked;

    // endpoint value or slope weight of tap k, rounded half away from zero
    function logic signed [63:0] tap_coef(int k, bit slope);
      longint n, nsq, se, ae, sk, ak, num;
      logic [127:0] den, scaled, quo, rem;
      n = sqfv_pkg::WINDOW;
      nsq = n * n;
      se = n - 1;
      ae = 3 * se * se - (nsq - 1);
      den = 4 * n * (nsq - 1) * (nsq - 4);
      sk = 2 * longint'(k) - (n - 1);
      ak = 3 * sk * sk - (nsq - 1);
      if (slope) begin
        num = 24 * sk * (nsq - 4) + 60 * ak * se;
      end else begin
        num = 4 * (nsq - 1) * (nsq - 4) + 12 * sk * se * (nsq - 4) + 5 * ak * ae;
      end
      scaled = (num < 0) ? -num : num;
      scaled = scaled << sqfv_pkg::COEF_FRAC_BITS;
      quo = scaled / den;
      rem = scaled % den;
      if ((rem << 1) >= den) quo = quo + 1;
      return (num < 0) ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

    function new();
      rate = sqfv_pkg::RATE_RESET;
      errors = 0;
      checked = 0;
      foreach (history[i]) history[i] = '0;
      for (int k = 0; k < sqfv_pkg::WINDOW; k++) begin
        pos_tap[k] = tap_coef(k, 1'b0);
        vel_tap[k] = tap_coef(k, 1'b1);
      end
    endfunction

    // add half an LSB, then arithmetic shift down to 16 fraction bits
    function logic signed [127:0] round_q16(logic signed [127:0] v);
      if (RND > 0) return (v + (128'sd1 <<< (RND - 1))) >>> RND;
      return v;
    endfunction

    function logic signed [127:0] saturate(logic signed [127:0] v, logic signed [127:0] hi);
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void note_sample(sqfv_pkg::sample_t s);
      logic signed [127:0] pos_acc, vel_acc, yk, slope;
      logic [127:0] mag, lim;
      sqfv_pkg::sample_t yv;
      bit neg;
      pos_acc = '0;
      vel_acc = '0;
      for (int k = 0; k < sqfv_pkg::WINDOW; k++) begin
        yv = (k == sqfv_pkg::WINDOW - 1) ? s : history[k];
        yk = yv;
        pos_acc = pos_acc + pos_tap[k] * yk;
        vel_acc = vel_acc + vel_tap[k] * yk;
      end
      expected_position.push_back(sqfv_pkg::result_t'(saturate(round_q16(pos_acc), POS_MAX)));
      // scale the slope magnitude by the rate, round half away from zero
      slope = saturate(round_q16(vel_acc), SLOPE_MAX);
      neg = slope < 0;
      mag = neg ? -slope : slope;
      mag = (mag * rate + 128'h8000) >> 16;
      lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
      if (mag > lim) mag = lim;
      expected_velocity.push_back(sqfv_pkg::result_t'(neg ? -mag : mag));
      for (int i = 0; i < sqfv_pkg::WINDOW - 2; i++) history[i] = history[i + 1];
      history[sqfv_pkg::WINDOW-2] = s;
    endfunction

    task report_mismatch(string what, sqfv_pkg::result_t got, sqfv_pkg::result_t want);
      if (errors < 40) begin
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      end
      errors++;
    endtask

    task check_result(sqfv_pkg::result_t pos, sqfv_pkg::result_t vel);
      sqfv_pkg::result_t want_pos, want_vel;
      checked++;
      if (expected_position.size() == 0) begin
        report_mismatch("unexpected transaction, position", pos, '0);
        return;
      end
      want_pos = expected_position.pop_front();
      want_vel = expected_velocity.pop_front();
      if (pos !== want_pos) report_mismatch("fitted_position", pos, want_pos);
      if (vel !== want_vel) report_mismatch("fitted_velocity", vel, want_vel);
    endtask

    function int pending();
      return expected_position.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sqfv_pkg::sample_t in_position_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sqfv_pkg::result_t out_fitted_position;
  sqfv_pkg::result_t out_fitted_velocity;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  sqfv_pkg::rate_t cfg_sample_rate = '0;

  velocity_fit_model fit = new();
  int send_pct = 0;
  int stall_pct = 0;
  int samples_sent = 0;
  int rate_writes = 0;
  int cycle_count = 0;

  sliding_quadratic_fit_velocity_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_position_sample  (in_position_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_fitted_position (out_fitted_position),
    .out_fitted_velocity (out_fitted_velocity),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sample_rate     (cfg_sample_rate)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL sliding_quadratic_fit_velocity_unit");
      $finish;
    end
  end

  // result side: check accepted transactions, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      fit.check_result(out_fitted_position, out_fitted_velocity);
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic push_sample(input sqfv_pkg::sample_t s);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_position_sample <= s;
    do @(posedge clk); while (in_stall);
    fit.note_sample(s);
    samples_sent++;
  endtask

  // hold off the sender until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (fit.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_sample_rate(input sqfv_pkg::rate_t r);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_sample_rate <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fit.rate = r;
    rate_writes++;
  endtask

  // one run of samples: mostly smooth trajectories, plus noise and extremes
  task automatic play_segment(input int len);
    int kind;
    sqfv_pkg::sample_t p, v, a, s;
    kind = $urandom_range(0, 9);
    p = $urandom;
    v = sqfv_pkg::sample_t'($urandom_range(0, 4000)) - 2000;
    a = sqfv_pkg::sample_t'($urandom_range(0, 40)) - 20;
    if ($urandom_range(0, 3) == 0) v = $urandom;
    for (int i = 0; i < len; i++) begin
      if (kind <= 5) begin
        s = p + sqfv_pkg::sample_t'($urandom_range(0, 6)) - 3;
        p = p + v;
        v = v + a;
        if ($urandom_range(0, 9) == 0) a = sqfv_pkg::sample_t'($urandom_range(0, 40)) - 20;
      end else if (kind <= 7) begin
        s = $urandom;
      end else if (kind == 8) begin
        case ($urandom_range(0, 4))
          0: s = SAMPLE_MAX;
          1: s = SAMPLE_MIN;
          2: s = '0;
          3: s = -1;
          default: s = 1;
        endcase
      end else begin
        s = sqfv_pkg::sample_t'($urandom_range(0, 200)) - 100;
      end
      push_sample(s);
    end
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_idle, input int count);
    int target;
    int len;
    sqfv_pkg::rate_t r;
    send_pct = sender_idle;
    stall_pct = receiver_idle;
    target = samples_sent + count;
    while (samples_sent < target) begin
      case ($urandom_range(0, 5))
        0: r = 32'd65536;
        1: r = 32'hFFFFFFFF;
        2: r = sqfv_pkg::RATE_RESET;
        3: r = '0;
        default: r = $urandom;
      endcase
      write_sample_rate(r);
      repeat ($urandom_range(2, 4)) begin
        len = $urandom_range(6, 30);
        if (len > target - samples_sent) len = target - samples_sent;
        play_segment(len);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window filling from zero at the reset rate, then full-scale swings
    push_sample('0);
    push_sample(SAMPLE_MAX);
    push_sample(SAMPLE_MIN);
    for (int i = 0; i < 8; i++) push_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);
    for (int i = 0; i < 3; i++) push_sample(sqfv_pkg::sample_t'(i * 1000));
    // largest rate to saturate velocity, then zero and sub-hertz rates
    write_sample_rate(32'hFFFFFFFF);
    for (int i = 0; i < 4; i++) push_sample(i[0] ? SAMPLE_MAX : SAMPLE_MIN);
    write_sample_rate('0);
    push_sample(SAMPLE_MAX);
    push_sample(sqfv_pkg::sample_t'(-12345));
    write_sample_rate(32'd1);
    push_sample(SAMPLE_MIN);
    push_sample(SAMPLE_MAX);

    run_phase(34, 63, 245);
    run_phase(63, 34, 245);
    run_phase(0, 0, 245);
    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d position samples over %0d sample rate settings, %0d fits checked",
             samples_sent, rate_writes, fit.checked);
    $display("Covered full-scale swings, zero and extreme rates, smooth and noisy tracks");
    if (fit.errors == 0 && fit.pending() == 0) begin
      $display("PASS sliding_quadratic_fit_velocity_unit");
    end else begin
      $display("FAIL sliding_quadratic_fit_velocity_unit");
    end
    $finish;
  end

endmodule
